/* hw/rtl/kmcq_pkg.sv */
// ----------------------------------------------------------------------------
// kmcq_pkg
// shared types and codes for the k-means color quantizer
// ----------------------------------------------------------------------------
package kmcq_pkg;

  localparam logic [1:0] OP_SEED  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int RESULT_LIMIT = 8;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } kmcq_in_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] cluster_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last;
  } kmcq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;   // capture input item
    logic seed_wr;     // write seed color
    logic dist_start;  // begin distance on cluster
    logic dist_step;   // one sqrt step
    logic dist_done;   // compare finished distance
    logic accum;       // add pixel to best cluster
    logic div_start;   // begin mean divisions for cluster
    logic div_step;    // one divider step
    logic div_commit;  // write mean to centroid
    logic load_out;    // load output register
    logic clear_sums;  // zero all sums and counts
    logic [3:0] idx;   // cluster under work
    logic out_kind;
    logic out_last;
  } kmcq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
  } kmcq_sts_t;

endpackage

/* hw/rtl/kmeans_color_quantizer.sv */
// ----------------------------------------------------------------------------
// kmeans_color_quantizer
// one k-means pass over streamed rgb pixels with centroid update
// ----------------------------------------------------------------------------
// seed: centroid write. pixel: per active cluster, distance by the 9-step sqrt
// end of pass: per active cluster, mean by the 26-step serial divider
// one item at a time; a waiting result only holds the next output load
// reset: centroids, sums and counts zero, clusters_in_use = 5
module kmeans_color_quantizer
  import kmcq_pkg::*;
#(
  parameter int MAX_CLUSTERS        = 8,
  parameter int MAX_PIXELS_PER_PASS = 262144
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  kmcq_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output kmcq_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  kmcq_cmd_t cmd;
  kmcq_sts_t sts;

  kmcq_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_valid, .cfg_ready, .cfg_data, .sts, .cmd
  );

  kmcq_datapath #(
    .MAX_CLUSTERS(MAX_CLUSTERS), .MAX_PIXELS_PER_PASS(MAX_PIXELS_PER_PASS)
  ) u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

endmodule

/* hw/rtl/kmcq_datapath.sv */
// ----------------------------------------------------------------------------
// kmcq_datapath
// centroid file, accumulators, serial sqrt and serial dividers
// ----------------------------------------------------------------------------
module kmcq_datapath
  import kmcq_pkg::*;
#(
  parameter int MAX_CLUSTERS        = 8,
  parameter int MAX_PIXELS_PER_PASS = 262144
) (
  input  logic      clk,
  input  logic      rst_n,
  input  kmcq_in_t  in_item,
  input  kmcq_cmd_t cmd,
  output kmcq_sts_t sts,
  output kmcq_out_t out_item
);

  localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  logic [23:0] cent_r [MAX_CLUSTERS];
  logic [25:0] rsum_r [MAX_CLUSTERS];
  logic [25:0] gsum_r [MAX_CLUSTERS];
  logic [25:0] bsum_r [MAX_CLUSTERS];
  logic [18:0] cnt_r  [MAX_CLUSTERS];

  kmcq_in_t    item_r;
  logic [IW-1:0] idx;
  logic [IW-1:0] best_r;
  logic [8:0]  bestd_r;
  logic [17:0] rad_r;
  logic [8:0]  root_r;
  logic [9:0]  rem_r;
  logic [3:0]  sq_cnt_r;

  // divider state: three quotients share one count
  logic [25:0] nr_r, ng_r, nb_r;
  logic [18:0] rr_r, rg_r, rb_r;
  logic [25:0] qr_r, qg_r, qb_r;

  assign idx = cmd.idx[IW-1:0];
  assign sts.op = item_r.op;

  // squared distance of the captured pixel to one centroid
  function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return 16'(d) * 16'(d);
  endfunction

  logic [17:0] dist_sq;
  always_comb begin
    dist_sq = 18'(sqd(item_r.red, cent_r[idx][23:16]))
            + 18'(sqd(item_r.green, cent_r[idx][15:8]))
            + 18'(sqd(item_r.blue, cent_r[idx][7:0]));
  end

  // restoring sqrt: one result bit a step, nine steps
  logic [11:0] trial;
  logic [11:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r, rad_r[17:16]};
    trial  = {1'b0, root_r, 2'b01};
  end

  // one restoring divide step for one channel
  function automatic logic [44:0] dstep(input logic [18:0] r, input logic [25:0] n,
                                        input logic [18:0] d);
    logic [19:0] s;
    s = {r, n[25]};
    if (s >= {1'b0, d}) return {19'(s - {1'b0, d}), n[24:0], 1'b1};
    return {s[18:0], n[24:0], 1'b0};
  endfunction

  logic [44:0] sr, sg, sb;
  logic [18:0] dv;
  assign dv = cnt_r[idx];
  assign sr = dstep(rr_r, nr_r, dv);
  assign sg = dstep(rg_r, ng_r, dv);
  assign sb = dstep(rb_r, nb_r, dv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cent_r[i] <= '0;
        rsum_r[i] <= '0;
        gsum_r[i] <= '0;
        bsum_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cmd.load_item) item_r <= in_item;
      if (cmd.seed_wr && 32'(item_r.slot) < MAX_CLUSTERS)
        cent_r[IW'(item_r.slot)] <= {item_r.red, item_r.green, item_r.blue};
      // distance
      if (cmd.dist_start) begin
        rad_r    <= dist_sq;
        root_r   <= '0;
        rem_r    <= '0;
        sq_cnt_r <= '0;
      end else if (cmd.dist_step) begin
        rad_r <= {rad_r[15:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= 10'(rem_sh - trial);
          root_r <= {root_r[7:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[9:0];
          root_r <= {root_r[7:0], 1'b0};
        end
        sq_cnt_r <= sq_cnt_r + 4'd1;
      end
      if (cmd.dist_done && (idx == '0 || root_r < bestd_r)) begin
        best_r  <= idx;
        bestd_r <= root_r;
      end
      if (cmd.accum && 32'(cnt_r[best_r]) < MAX_PIXELS_PER_PASS) begin
        rsum_r[best_r] <= rsum_r[best_r] + 26'(item_r.red);
        gsum_r[best_r] <= gsum_r[best_r] + 26'(item_r.green);
        bsum_r[best_r] <= bsum_r[best_r] + 26'(item_r.blue);
        cnt_r[best_r]  <= cnt_r[best_r] + 19'd1;
      end
      // means
      if (cmd.div_start) begin
        nr_r <= rsum_r[idx]; ng_r <= gsum_r[idx]; nb_r <= bsum_r[idx];
        rr_r <= '0; rg_r <= '0; rb_r <= '0;
      end else if (cmd.div_step) begin
        rr_r <= sr[44:26]; nr_r <= sr[25:0]; qr_r <= {qr_r[24:0], sr[0]};
        rg_r <= sg[44:26]; ng_r <= sg[25:0]; qg_r <= {qg_r[24:0], sg[0]};
        rb_r <= sb[44:26]; nb_r <= sb[25:0]; qb_r <= {qb_r[24:0], sb[0]};
      end
      if (cmd.div_commit && cnt_r[idx] != '0)
        cent_r[idx] <= {qr_r[7:0], qg_r[7:0], qb_r[7:0]};
      if (cmd.clear_sums) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          rsum_r[i] <= '0; gsum_r[i] <= '0; bsum_r[i] <= '0; cnt_r[i] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.kind          <= cmd.out_kind;
      out_item.last          <= cmd.out_last;
      out_item.cluster_index <= (cmd.out_kind == KIND_ASSIGN) ? 3'(best_r) : 3'(idx);
      {out_item.out_red, out_item.out_green, out_item.out_blue} <=
        (cmd.out_kind == KIND_ASSIGN) ? cent_r[best_r] : cent_r[idx];
    end
  end

  // sqrt counter must not run past nine steps
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dist_step |-> sq_cnt_r < 4'd9) else $error("sqrt overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum |-> !cmd.clear_sums) else $error("accumulate during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dist_done |=> bestd_r <= $past(root_r) || $past(idx) != '0)
    else $error("best distance not tracked");

endmodule

/* hw/rtl/kmcq_ctrl.sv */
// ----------------------------------------------------------------------------
// kmcq_ctrl
// sequencer for seed, pixel and end-of-pass items
// ----------------------------------------------------------------------------
module kmcq_ctrl
  import kmcq_pkg::*;
#(
  parameter int MAX_CLUSTERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data,
  input  kmcq_sts_t sts,
  output kmcq_cmd_t cmd
);

  localparam int LIM = (MAX_CLUSTERS < RESULT_LIMIT) ? MAX_CLUSTERS : RESULT_LIMIT;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIST, S_SQRT, S_ACC, S_DIV, S_EMIT, S_WAIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] ciu_r, ciu_nxt;
  logic [3:0] n;
  logic [3:0] idx_r, idx_nxt;
  logic [4:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;

  // active cluster count with range clamp
  always_comb begin
    n = ciu_r;
    if (n == 4'd0) n = 4'd1;
    if (32'(n) > LIM) n = 4'(LIM);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    ciu_nxt   = ciu_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (cfg_valid) ciu_nxt = cfg_data;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load_item = 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        idx_nxt = '0;
        unique case (sts.op)
          OP_SEED:  begin cmd.seed_wr = 1'b1; state_nxt = S_IDLE; end
          OP_PIXEL: state_nxt = S_DIST;
          OP_END:   state_nxt = S_DIV;
          default:  state_nxt = S_IDLE;
        endcase
        step_nxt = '0;
      end
      S_DIST: begin
        cmd.dist_start = 1'b1;
        step_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (step_r < 5'd9) begin
          cmd.dist_step = 1'b1;
          step_nxt = step_r + 5'd1;
        end else begin
          cmd.dist_done = 1'b1;
          if (idx_r + 4'd1 == n) state_nxt = S_ACC;
          else begin
            idx_nxt = idx_r + 4'd1;
            state_nxt = S_DIST;
          end
        end
      end
      S_ACC: if (!ov_nxt) begin
        cmd.accum = 1'b1;
        cmd.load_out = 1'b1;
        cmd.out_kind = KIND_ASSIGN;
        cmd.out_last = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (step_r == 5'd0) begin
          cmd.div_start = 1'b1;
          step_nxt = 5'd1;
        end else if (step_r <= 5'd26) begin
          cmd.div_step = 1'b1;
          step_nxt = step_r + 5'd1;
        end else begin
          cmd.div_commit = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: if (!ov_nxt) begin
        cmd.load_out = 1'b1;
        cmd.out_kind = KIND_REPORT;
        cmd.out_last = (idx_r + 4'd1 == n);
        ov_nxt = 1'b1;
        step_nxt = '0;
        if (idx_r + 4'd1 == n) state_nxt = S_WAIT;
        else begin
          idx_nxt = idx_r + 4'd1;
          state_nxt = S_DIV;
        end
      end
      S_WAIT: begin
        cmd.clear_sums = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ciu_r   <= 4'd5;
      idx_r   <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ciu_r   <= ciu_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !ov_r || !out_stall) else $error("output overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < n || state_r == S_IDLE || state_r == S_DECODE) else $error("index range");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives seed, pixel and end-of-pass items into the k-means color quantizer,
// predicts every cluster assignment and centroid report, and checks each one
// ----------------------------------------------------------------------------
module testbench;
  import kmcq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLUST = 8;
  localparam int PIX_CAP = 262144;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kmcq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kmcq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  kmeans_color_quantizer #(.MAX_CLUSTERS(NCLUST), .MAX_PIXELS_PER_PASS(PIX_CAP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predicted cluster state
  logic [3:0] clusters_reg;
  logic [23:0] centroid [NCLUST];
  logic [25:0] sum_r [NCLUST];
  logic [25:0] sum_g [NCLUST];
  logic [25:0] sum_b [NCLUST];
  logic [18:0] members [NCLUST];
  kmcq_out_t expected_results[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int active_clusters();
    int n;
    n = clusters_reg;
    if (n == 0) n = 1;
    if (n > NCLUST) n = NCLUST;
    return n;
  endfunction

  function automatic int isqrt(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int color_dist(input kmcq_in_t it, input logic [23:0] c);
    int dr, dg, db;
    dr = int'(it.red) - int'(c[23:16]);
    dg = int'(it.green) - int'(c[15:8]);
    db = int'(it.blue) - int'(c[7:0]);
    return isqrt(dr * dr + dg * dg + db * db);
  endfunction

  // update predicted state and queue the results of one item
  task automatic predict_item(input kmcq_in_t it);
    int n, best, best_d, d;
    kmcq_out_t r;
    n = active_clusters();
    if (it.op == OP_SEED) begin
      centroid[it.slot] = {it.red, it.green, it.blue};
    end else if (it.op == OP_PIXEL) begin
      best = 0;
      best_d = 0;
      for (int k = 0; k < n; k++) begin
        d = color_dist(it, centroid[k]);
        if (k == 0 || d < best_d) begin
          best = k;
          best_d = d;
        end
      end
      if (members[best] < PIX_CAP) begin
        sum_r[best] += it.red;
        sum_g[best] += it.green;
        sum_b[best] += it.blue;
        members[best] += 1;
      end
      r = '{kind: KIND_ASSIGN, cluster_index: best[2:0], out_red: centroid[best][23:16],
            out_green: centroid[best][15:8], out_blue: centroid[best][7:0], last: 1'b1};
      expected_results = {expected_results, r};
    end else if (it.op == OP_END) begin
      for (int k = 0; k < n; k++) begin
        if (members[k] != 0)
          centroid[k] = {8'(sum_r[k] / members[k]), 8'(sum_g[k] / members[k]),
                         8'(sum_b[k] / members[k])};
        r = '{kind: KIND_REPORT, cluster_index: k[2:0], out_red: centroid[k][23:16],
              out_green: centroid[k][15:8], out_blue: centroid[k][7:0],
              last: (k + 1 == n)};
        expected_results = {expected_results, r};
      end
      for (int k = 0; k < NCLUST; k++) begin
        sum_r[k] = '0; sum_g[k] = '0; sum_b[k] = '0; members[k] = '0;
      end
    end
  endtask

  // send one item, with bursty sender gaps
  task automatic send_item(input kmcq_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // drained write of the cluster count register
  task automatic set_clusters(input logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    clusters_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic kmcq_in_t make_item(input logic [1:0] op, input logic [2:0] slot,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    kmcq_in_t it;
    it.op = op; it.slot = slot; it.red = r; it.green = g; it.blue = b;
    return it;
  endfunction

  function automatic kmcq_in_t random_color(input logic [1:0] op);
    return make_item(op, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // extremes, ties, unused op and an empty cluster at default register value
  task automatic test_directed();
    send_item(make_item(OP_SEED, 3'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(OP_SEED, 3'd1, 8'd255, 8'd255, 8'd255));
    send_item(make_item(OP_SEED, 3'd7, 8'd10, 8'd20, 8'd30));
    send_item(make_item(OP_PIXEL, 3'd7, 8'd255, 8'd255, 8'd255));
    send_item(make_item(OP_PIXEL, 3'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(OP_PIXEL, 3'd2, 8'd128, 8'd127, 8'd128));
    send_item(make_item(2'd3, 3'd5, 8'd255, 8'd0, 8'd255));
    send_item(make_item(OP_PIXEL, 3'd0, 8'd200, 8'd1, 8'd90));
    send_item(make_item(OP_END, 3'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(OP_END, 3'd7, 8'd255, 8'd255, 8'd255));
  endtask

  // register extremes, including the out-of-range values
  task automatic test_register_range();
    logic [3:0] vals [4] = '{4'd0, 4'd1, 4'd15, 4'd8};
    foreach (vals[i]) begin
      set_clusters(vals[i]);
      for (int s = 0; s < 8; s++) send_item(random_color(OP_SEED));
      for (int p = 0; p < 5; p++) send_item(random_color(OP_PIXEL));
      send_item(make_item(OP_END, 3'd0, 8'd0, 8'd0, 8'd0));
    end
  endtask

  // full passes with random seeds and pixels, a little noise
  task automatic test_random_passes();
    int pick;
    for (int pass = 0; pass < 6; pass++) begin
      if (pass == 2) set_clusters(4'($urandom_range(2, 7)));
      if (pass == 4) set_clusters(4'd8);
      for (int s = 0; s < active_clusters(); s++)
        send_item(make_item(OP_SEED, s[2:0], 8'($urandom), 8'($urandom), 8'($urandom)));
      for (int p = 0; p < 8; p++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_item(random_color(2'd3));
        else if (pick == 1) send_item(random_color(OP_SEED));
        else send_item(random_color(OP_PIXEL));
      end
      if (pass == 3) drain();
      send_item(random_color(OP_END));
    end
  endtask

  // receiver stall pattern with calm stretches
  always @(negedge clk) begin
    if ((int'($realtime) / 200) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) == 0);
  end

  // result checker
  always @(posedge clk) begin
    kmcq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.cluster_index !== want.cluster_index)
          report_mismatch("cluster_index", out_data.cluster_index, want.cluster_index);
        if (out_data.out_red !== want.out_red)
          report_mismatch("out_red", out_data.out_red, want.out_red);
        if (out_data.out_green !== want.out_green)
          report_mismatch("out_green", out_data.out_green, want.out_green);
        if (out_data.out_blue !== want.out_blue)
          report_mismatch("out_blue", out_data.out_blue, want.out_blue);
        if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clusters_reg = 4'd5;
    for (int k = 0; k < NCLUST; k++) begin
      centroid[k] = '0; sum_r[k] = '0; sum_g[k] = '0; sum_b[k] = '0; members[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_range();
    test_random_passes();
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* kmeans_color_quantizer.f */
hw/rtl/kmcq_pkg.sv
hw/rtl/kmcq_datapath.sv
hw/rtl/kmcq_ctrl.sv
hw/rtl/kmeans_color_quantizer.sv
test/testbench.sv
